/* hdl/dns_label_list_to_text_unit_defines.svh */
// Assertion macros for the DNS label list to text unit.
`ifndef DNS_LABEL_LIST_TO_TEXT_UNIT_DEFINES_SVH
`define DNS_LABEL_LIST_TO_TEXT_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define DLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define DLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/dnslbl_pkg.sv */
// Package: constants, status codes and helpers of the DNS label list to text unit.
package dnslbl_pkg;

	localparam int NAME_MAX_BYTES = 256;
	localparam int NB_W = $clog2(NAME_MAX_BYTES + 1);
	localparam int LEN_MAX = 63;
	localparam int PTR_MIN = 192;
	localparam int PADDR_W = 3;
	localparam logic [15:0] MAX_OUT_RST = 16'd512;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	typedef enum logic [PADDR_W-3:0] {
		REG_MAX_OUT = 1'b0
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_LEN  = 3'd1,
		ST_POINTER  = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_BAD_CHAR = 3'd4,
		ST_TOO_LONG = 3'd5,
		ST_EMPTY    = 3'd6,
		ST_NO_SPACE = 3'd7
	} status_t;

	// letters, digits and hyphen
	function automatic logic ldh_char(input logic [7:0] c);
		logic ok;
		ok = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
		     ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h2D);
		return ok;
	endfunction

endpackage

/* hdl/dns_label_list_to_text_unit.sv */
// An input transaction passes the input register, then the result register.
// Throughput: one byte per cycle unless res_ready stalls; decode, counter update and
// compare sit between input and result registers; the result register frees when taken.
// Reset: asynchronous, active low; clears all control state and sets max_out to 512.
// State also returns to reset after every result marked final.
// Top level: DNS label list to text converter with an APB register port.
`include "dns_label_list_to_text_unit_defines.svh"

module dns_label_list_to_text_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dnslbl_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic [7:0]                      in_byte,
	input  logic                            last_byte,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic                            char_valid,
	output logic [7:0]                      out_char,
	output logic                            final_res,
	output logic [2:0]                      status,
	output logic [15:0]                     out_length
);

	localparam int NB_W = dnslbl_pkg::NB_W;

	logic [15:0]      max_out_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic             in_label_q;
	logic [5:0]       label_left_q;
	logic [NB_W-1:0]  name_bytes_q;
	logic [15:0]      committed_q;
	logic             have_name_q;
	dnslbl_pkg::status_t err_q;

	logic             in_label_d;
	logic [5:0]       label_left_d;
	logic [NB_W-1:0]  name_bytes_d;
	logic [15:0]      committed_d;
	logic             have_name_d;
	dnslbl_pkg::status_t err_d;
	logic             cv_d;
	logic [7:0]       ch_d;
	dnslbl_pkg::status_t status_d;
	logic [15:0]      len_d;

	logic             out_free;
	logic             move;
	logic             wr_en;
	logic [16:0]      commit_sum;
	logic [NB_W-1:0]  nb_inc;
	logic [5:0]       left_dec;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite &&
	                  (paddr[dnslbl_pkg::PADDR_W-1:2] == dnslbl_pkg::REG_MAX_OUT);
	assign prdata   = (paddr[dnslbl_pkg::PADDR_W-1:2] == dnslbl_pkg::REG_MAX_OUT) ?
	                  {16'd0, max_out_q} : 32'd0;

	assign out_free   = !res_valid || res_ready;
	assign move       = valid_s1 && out_free;
	assign item_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_out_q <= dnslbl_pkg::MAX_OUT_RST;
		end else if (wr_en) begin
			max_out_q <= pwdata[15:0];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= last_byte;
		end
	end

	assign commit_sum = {1'b0, committed_q} + 17'(name_bytes_q);
	assign nb_inc     = name_bytes_q + NB_W'(1);
	assign left_dec   = label_left_q - 6'd1;

	always_comb begin
		in_label_d   = in_label_q;
		label_left_d = label_left_q;
		name_bytes_d = name_bytes_q;
		committed_d  = committed_q;
		have_name_d  = have_name_q;
		err_d        = err_q;
		cv_d         = 1'b0;
		ch_d         = 8'd0;
		status_d     = dnslbl_pkg::ST_OK;
		len_d        = 16'd0;

		if (err_q == dnslbl_pkg::ST_OK) begin
			if (!in_label_q) begin
				if (byte_s1 == 8'd0) begin
					if (name_bytes_q == '0) begin
						err_d = dnslbl_pkg::ST_EMPTY;
					end else if (commit_sum >= {1'b0, max_out_q}) begin
						err_d = dnslbl_pkg::ST_NO_SPACE;
					end else begin
						committed_d  = commit_sum[15:0];
						have_name_d  = 1'b1;
						name_bytes_d = '0;
					end
				end else if (byte_s1 <= 8'(dnslbl_pkg::LEN_MAX)) begin
					if (name_bytes_q != '0) begin
						cv_d = 1'b1;
						ch_d = dnslbl_pkg::CH_DOT;
					end else if (have_name_q) begin
						cv_d = 1'b1;
						ch_d = dnslbl_pkg::CH_COMMA;
					end
					in_label_d   = 1'b1;
					label_left_d = byte_s1[5:0];
				end else if (byte_s1 < 8'(dnslbl_pkg::PTR_MIN)) begin
					err_d = dnslbl_pkg::ST_BAD_LEN;
				end else begin
					err_d = dnslbl_pkg::ST_POINTER;
				end
			end else begin
				if (32'(name_bytes_q) >= dnslbl_pkg::NAME_MAX_BYTES) begin
					err_d = dnslbl_pkg::ST_TOO_LONG;
				end else if (!dnslbl_pkg::ldh_char(byte_s1)) begin
					err_d = dnslbl_pkg::ST_BAD_CHAR;
				end else begin
					cv_d         = 1'b1;
					ch_d         = byte_s1;
					name_bytes_d = nb_inc;
					label_left_d = left_dec;
					if (left_dec == 6'd0) begin
						in_label_d = 1'b0;
						if (32'(nb_inc) >= dnslbl_pkg::NAME_MAX_BYTES) begin
							err_d = dnslbl_pkg::ST_TOO_LONG;
						end else begin
							name_bytes_d = nb_inc + NB_W'(1);
						end
					end
				end
			end
		end

		if (last_s1) begin
			if ((err_d == dnslbl_pkg::ST_OK) && in_label_d) begin
				err_d = dnslbl_pkg::ST_TRUNC;
			end
			status_d = err_d;
			if ((err_d == dnslbl_pkg::ST_OK) && have_name_d && (committed_d != 16'd0)) begin
				len_d = committed_d - 16'd1;
			end
			in_label_d   = 1'b0;
			label_left_d = 6'd0;
			name_bytes_d = '0;
			committed_d  = 16'd0;
			have_name_d  = 1'b0;
			err_d        = dnslbl_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_label_q   <= 1'b0;
			label_left_q <= 6'd0;
			name_bytes_q <= '0;
			committed_q  <= 16'd0;
			have_name_q  <= 1'b0;
			err_q        <= dnslbl_pkg::ST_OK;
		end else if (move) begin
			in_label_q   <= in_label_d;
			label_left_q <= label_left_d;
			name_bytes_q <= name_bytes_d;
			committed_q  <= committed_d;
			have_name_q  <= have_name_d;
			err_q        <= err_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_free) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			char_valid <= cv_d;
			out_char   <= ch_d;
			final_res  <= last_s1;
			status     <= status_d;
			out_length <= len_d;
		end
	end

	`DLT_ASSERT_IMPL(a_len_only_final_ok, clk, arst_n, res_valid && (out_length != 16'd0),
		final_res && (status == dnslbl_pkg::ST_OK))
	`DLT_ASSERT_IMPL(a_status_only_final, clk, arst_n, res_valid && (status != dnslbl_pkg::ST_OK),
		final_res)
	`DLT_ASSERT_NEXT(a_silent_after_error, clk, arst_n, move && (err_q != dnslbl_pkg::ST_OK),
		res_valid && !char_valid)
	`DLT_ASSERT_NEXT(a_clear_after_final, clk, arst_n, move && last_s1,
		(err_q == dnslbl_pkg::ST_OK) && !in_label_q && (name_bytes_q == '0) && !have_name_q)
	`DLT_ASSERT_IMPL(a_ready_when_drained, clk, arst_n, !res_valid, item_ready)

endmodule

/* verif/dns_label_list_to_text_unit_tb.sv */
// Testbench for dns_label_list_to_text_unit: directed table and random label streams; results pinned or predicted.
`timescale 1ns / 100ps

module dns_label_list_to_text_unit_tb;

	typedef struct packed {
		logic       cv;
		logic [7:0] ch;
		logic       fin;
		dnslbl_pkg::status_t st;
		logic [15:0] len;
	} text_res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       typed;
		text_res_t  res;
	} dir_row_t;

	localparam logic [dnslbl_pkg::PADDR_W-1:0] MAX_OUT_ADDR = {dnslbl_pkg::REG_MAX_OUT, 2'b00};
	localparam text_res_t NO_PIN = '0;
	localparam int RAND_ITEMS = 1500;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [dnslbl_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic item_valid, item_ready;
	logic [7:0] in_byte;
	logic last_byte;
	logic res_valid, res_ready;
	logic char_valid;
	logic [7:0] out_char;
	logic final_res;
	logic [2:0] status;
	logic [15:0] out_length;

	dns_label_list_to_text_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_ready(item_ready),
		.in_byte(in_byte), .last_byte(last_byte),
		.res_valid(res_valid), .res_ready(res_ready),
		.char_valid(char_valid), .out_char(out_char), .final_res(final_res),
		.status(status), .out_length(out_length)
	);

	always #5 clk = ~clk;

	// predictor state
	logic                        lbl_open = 1'b0;
	logic [5:0]                  lbl_left = '0;
	logic [dnslbl_pkg::NB_W-1:0] nm_bytes = '0;
	logic [15:0]                 done_len = '0;
	logic                        any_name = 1'b0;
	dnslbl_pkg::status_t         err = dnslbl_pkg::ST_OK;
	logic [15:0]                 cfg_max = dnslbl_pkg::MAX_OUT_RST;

	text_res_t text_q [$];
	logic [7:0] msg_q [$];
	logic pin_on = 1'b0;
	text_res_t pin_res = '0;
	int fails = 0;
	int tx_calm = 0;
	int rx_calm = 0;
	int rx_hold = 0;
	string ldh_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";
	dir_row_t dir_tab [24];

	function automatic logic is_ldh(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
		       (c >= "0" && c <= "9") || (c == "-");
	endfunction

	function automatic text_res_t render_byte(input logic [7:0] b, input logic l);
		text_res_t r;
		r = '0;
		if (err == dnslbl_pkg::ST_OK) begin
			if (!lbl_open) begin
				if (b == 8'd0) begin
					if (nm_bytes == 0) begin
						err = dnslbl_pkg::ST_EMPTY;
					end else if (int'(done_len) + int'(nm_bytes) >= int'(cfg_max)) begin
						err = dnslbl_pkg::ST_NO_SPACE;
					end else begin
						done_len = done_len + 16'(nm_bytes);
						any_name = 1'b1;
						nm_bytes = '0;
					end
				end else if (b <= dnslbl_pkg::LEN_MAX) begin
					if (nm_bytes != 0) begin
						r.cv = 1'b1;
						r.ch = dnslbl_pkg::CH_DOT;
					end else if (any_name) begin
						r.cv = 1'b1;
						r.ch = dnslbl_pkg::CH_COMMA;
					end
					lbl_open = 1'b1;
					lbl_left = b[5:0];
				end else if (b < dnslbl_pkg::PTR_MIN) begin
					err = dnslbl_pkg::ST_BAD_LEN;
				end else begin
					err = dnslbl_pkg::ST_POINTER;
				end
			end else begin
				if (nm_bytes >= dnslbl_pkg::NAME_MAX_BYTES) begin
					err = dnslbl_pkg::ST_TOO_LONG;
				end else if (!is_ldh(b)) begin
					err = dnslbl_pkg::ST_BAD_CHAR;
				end else begin
					r.cv = 1'b1;
					r.ch = b;
					nm_bytes = nm_bytes + 1'b1;
					lbl_left = lbl_left - 1'b1;
					if (lbl_left == 0) begin
						lbl_open = 1'b0;
						if (nm_bytes >= dnslbl_pkg::NAME_MAX_BYTES)
							err = dnslbl_pkg::ST_TOO_LONG;
						else
							nm_bytes = nm_bytes + 1'b1;
					end
				end
			end
		end
		if (l) begin
			if (err == dnslbl_pkg::ST_OK && lbl_open)
				err = dnslbl_pkg::ST_TRUNC;
			r.fin = 1'b1;
			r.st = err;
			if (err == dnslbl_pkg::ST_OK && any_name && done_len > 0)
				r.len = done_len - 1'b1;
			lbl_open = 1'b0;
			lbl_left = '0;
			nm_bytes = '0;
			done_len = '0;
			any_name = 1'b0;
			err = dnslbl_pkg::ST_OK;
		end
		return r;
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] ldh_pick();
		return ldh_set[$urandom_range(0, 62)];
	endfunction

	task automatic check_field(input string nm, input logic [15:0] want_v,
	                           input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s expected %0h got %0h", nm, want_v, got_v);
			fails++;
		end
	endtask

	// result check first, then prediction of the transaction accepted at this edge
	always @(posedge clk) begin
		text_res_t got, want, pred;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				got = {char_valid, out_char, final_res, status, out_length};
				if (text_q.size() == 0) begin
					$error("result transaction with nothing expected");
					fails++;
				end else begin
					want = text_q.pop_front();
					check_field("char_valid", want.cv, got.cv);
					check_field("out_char", want.ch, got.ch);
					check_field("final_res", want.fin, got.fin);
					check_field("status", want.st, got.st);
					check_field("out_length", want.len, got.len);
				end
			end
			if (item_valid && item_ready) begin
				pred = render_byte(in_byte, last_byte);
				if (pin_on)
					pred = pin_res;
				text_q.push_back(pred);
			end
			if (psel && penable && pwrite && pready && paddr == MAX_OUT_ADDR)
				cfg_max = pwdata[15:0];
		end
	end

	// result side back-pressure
	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				res_ready <= 1'b0;
				rx_hold--;
			end else begin
				res_ready <= 1'b1;
				if (rx_calm > 0) begin
					rx_calm--;
				end else begin
					rx_hold = pause_len();
					if ($urandom_range(0, 199) == 0)
						rx_calm = $urandom_range(50, 150);
				end
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b, input logic l, input logic pin,
	                         input text_res_t pres);
		int gap;
		if (tx_calm > 0) begin
			tx_calm--;
			gap = 0;
		end else begin
			gap = pause_len();
			if ($urandom_range(0, 199) == 0)
				tx_calm = $urandom_range(50, 150);
		end
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		in_byte <= b;
		last_byte <= l;
		pin_on = pin;
		pin_res = pres;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	// drains the block, then writes max_out and reads it back
	task automatic write_max_out(input logic [15:0] v);
		item_valid <= 1'b0;
		while (text_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= MAX_OUT_ADDR;
		pwdata <= {16'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== v) begin
			$error("max_out readback expected %0h got %0h", v, prdata[15:0]);
			fails++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic build_msg();
		int kind, n_names, n_lbls, llen, cut;
		msg_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n_names = (kind >= 97) ? 1 : $urandom_range(1, 3);
		for (int n = 0; n < n_names; n++) begin
			if (kind >= 97)
				n_lbls = $urandom_range(4, 5);
			else if ($urandom_range(0, 15) == 0)
				n_lbls = 0;
			else
				n_lbls = $urandom_range(1, 3);
			for (int k = 0; k < n_lbls; k++) begin
				if (kind >= 97)
					llen = $urandom_range(48, 63);
				else if ($urandom_range(0, 19) == 0)
					llen = dnslbl_pkg::LEN_MAX;
				else
					llen = $urandom_range(1, 6);
				msg_q.push_back(8'(llen));
				repeat (llen) msg_q.push_back(ldh_pick());
			end
			msg_q.push_back(8'd0);
		end
		if (kind < 20) begin
			repeat ($urandom_range(1, 2))
				msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (kind < 30) begin
			cut = $urandom_range(0, msg_q.size() - 1);
			msg_q = msg_q[0:cut];
		end
	endtask

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int sent;
		int phase;
		int pick;
		logic [15:0] mo;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		in_byte = '0;
		last_byte = 1'b0;
		dir_tab = '{
			'{8'd0,   1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, dnslbl_pkg::ST_EMPTY,    16'd0}},
			'{8'd64,  1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, dnslbl_pkg::ST_BAD_LEN,  16'd0}},
			'{8'd191, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, dnslbl_pkg::ST_BAD_LEN,  16'd0}},
			'{8'd192, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, dnslbl_pkg::ST_POINTER,  16'd0}},
			'{8'd255, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, dnslbl_pkg::ST_POINTER,  16'd0}},
			'{8'd3,   1'b0, 1'b1, '{1'b0, 8'd0, 1'b0, dnslbl_pkg::ST_OK,       16'd0}},
			'{"a",    1'b0, 1'b0, NO_PIN},
			'{"Z",    1'b0, 1'b0, NO_PIN},
			'{"9",    1'b1, 1'b1, '{1'b1, "9",  1'b1, dnslbl_pkg::ST_OK,       16'd0}},
			'{8'd1,   1'b0, 1'b0, NO_PIN},
			'{"-",    1'b0, 1'b0, NO_PIN},
			'{8'd0,   1'b0, 1'b0, NO_PIN},
			'{8'd2,   1'b0, 1'b0, NO_PIN},
			'{"x",    1'b0, 1'b0, NO_PIN},
			'{"y",    1'b0, 1'b0, NO_PIN},
			'{8'd0,   1'b1, 1'b0, NO_PIN},
			'{8'd1,   1'b0, 1'b0, NO_PIN},
			'{"!",    1'b0, 1'b0, NO_PIN},
			'{8'd5,   1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, dnslbl_pkg::ST_BAD_CHAR, 16'd0}},
			'{8'd2,   1'b0, 1'b0, NO_PIN},
			'{"a",    1'b1, 1'b1, '{1'b1, "a",  1'b1, dnslbl_pkg::ST_TRUNC,    16'd0}},
			'{8'd1,   1'b0, 1'b0, NO_PIN},
			'{8'd0,   1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, dnslbl_pkg::ST_BAD_CHAR, 16'd0}},
			'{8'd63,  1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, dnslbl_pkg::ST_TRUNC,    16'd0}}
		};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_byte(dir_tab[i].b, dir_tab[i].l, dir_tab[i].typed, dir_tab[i].res);

		sent = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			pick = $urandom_range(0, 4);
			if (phase == 0)
				mo = 16'd1;
			else if (phase == 1)
				mo = 16'hFFFF;
			else if (pick == 0)
				mo = 16'd1;
			else if (pick == 1)
				mo = 16'hFFFF;
			else if (pick == 2)
				mo = dnslbl_pkg::MAX_OUT_RST;
			else if (pick == 3)
				mo = 16'($urandom_range(2, 60));
			else
				mo = 16'($urandom_range(1, 65535));
			write_max_out(mo);
			repeat ($urandom_range(1, 3)) begin
				build_msg();
				foreach (msg_q[j]) begin
					send_byte(msg_q[j], j == msg_q.size() - 1, 1'b0, NO_PIN);
					sent++;
				end
			end
			phase++;
		end

		item_valid <= 1'b0;
		while (text_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fails == 0 && text_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
